// ===== src/kmsd_pkg.sv =====
// Shared types, constants and the key map of the keypad scanner.
`timescale 1ns / 1ps

package kmsd_pkg;

  // Request kinds on the input channel.
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result codes with a special meaning.
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_HELD = 8'hFF;

  // Column patterns with exactly one low bit, searched C4 first.
  localparam logic [3:0] COL_C4 = 4'h7;
  localparam logic [3:0] COL_C3 = 4'hB;
  localparam logic [3:0] COL_C2 = 4'hD;
  localparam logic [3:0] COL_C1 = 4'hE;

  // Debounce register width and its value after reset.
  localparam int DebW = 4;
  localparam logic [DebW-1:0] DEBOUNCE_RESET = 4'd3;

  // Repeat counter, one bit wider than the debounce register.
  localparam int CntW = DebW + 1;

  // Number of rows scanned in one tick.
  localparam int Rows = 4;

  // What one row lane found.
  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } lane_hit_t;

  // Decoded request handed to the debounce stage.
  typedef struct packed {
    logic       read;
    logic [7:0] key;
  } scan_req_t;

  // Key map by row (0 = R4 .. 3 = R1) and column (0 = C4 .. 3 = C1).
  localparam logic [7:0] KEY_MAP [Rows][4] = '{
    '{8'h44, 8'h23, 8'h30, 8'h2A},
    '{8'h43, 8'h39, 8'h38, 8'h37},
    '{8'h42, 8'h36, 8'h35, 8'h34},
    '{8'h41, 8'h33, 8'h32, 8'h31}
  };

  function automatic logic [7:0] key_of(input logic [1:0] row, input logic [1:0] col);
    return KEY_MAP[row][col];
  endfunction

endpackage

// ===== src/kmsd_if.sv =====
// Channel interfaces of the keypad scanner: request, result and configuration.
`timescale 1ns / 1ps

interface kmsd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [3:0] cols_row4;
  logic [3:0] cols_row3;
  logic [3:0] cols_row2;
  logic [3:0] cols_row1;

  modport source (output valid, req_type, cols_row4, cols_row3, cols_row2, cols_row1,
                  input ready);
  modport sink (input valid, req_type, cols_row4, cols_row3, cols_row2, cols_row1,
                output ready);
endinterface

interface kmsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_code;

  modport source (output valid, result_code, input ready);
  modport sink (input valid, result_code, output ready);
endinterface

interface kmsd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kmsd_pkg::DebW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/kmsd_row_lane.sv =====
// One row lane: checks a row's column sample for a single low column.
`timescale 1ns / 1ps

module kmsd_row_lane (
  input  logic [3:0]          cols,
  output kmsd_pkg::lane_hit_t found
);

  // A row matches only when exactly one column bit is low.
  always_comb begin
    found.hit = 1'b1;
    found.col = 2'd0;
    case (cols)
      kmsd_pkg::COL_C4: found.col = 2'd0;
      kmsd_pkg::COL_C3: found.col = 2'd1;
      kmsd_pkg::COL_C2: found.col = 2'd2;
      kmsd_pkg::COL_C1: found.col = 2'd3;
      default:          found.hit = 1'b0;
    endcase
  end

endmodule

// ===== src/kmsd_merge.sv =====
// Merging stage: picks the first matching row, R4 first, and maps it to a key.
`timescale 1ns / 1ps

module kmsd_merge (
  input  kmsd_pkg::lane_hit_t lanes [kmsd_pkg::Rows],
  output logic [7:0]          key
);

  // Priority select over the lanes; no hit gives the no-key code.
  always_comb begin
    key = kmsd_pkg::KEY_NONE;
    for (int r = kmsd_pkg::Rows - 1; r >= 0; r--) begin
      if (lanes[r].hit) begin
        key = kmsd_pkg::key_of(2'(r), lanes[r].col);
      end
    end
  end

endmodule

// ===== src/kmsd_debounce.sv =====
// Debounce state, read handling and the two-entry result buffer.
`timescale 1ns / 1ps

module kmsd_debounce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  kmsd_pkg::scan_req_t       req,
  input  logic                      cfg_valid,
  input  logic [kmsd_pkg::DebW-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_code
);

  logic [kmsd_pkg::DebW-1:0] debounce_ticks;
  logic [7:0]                prev_key;
  logic [7:0]                prev_key_next;
  logic [kmsd_pkg::CntW-1:0] stable_count;
  logic [kmsd_pkg::CntW-1:0] stable_count_next;
  logic                      key_ready;
  logic                      key_ready_next;
  logic [7:0]                accepted_key;
  logic [7:0]                accepted_key_next;
  logic [7:0]                result;
  logic                      skid_valid;
  logic [7:0]                skid_code;
  logic                      push;
  logic                      pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Next debounce state and the result of the current request.
  always_comb begin
    prev_key_next     = prev_key;
    stable_count_next = stable_count;
    key_ready_next    = key_ready;
    accepted_key_next = accepted_key;
    result            = req.key;
    if (req.read == kmsd_pkg::REQ_READ) begin
      if (key_ready) begin
        key_ready_next = 1'b0;
        result         = accepted_key;
      end else begin
        result = kmsd_pkg::KEY_HELD;
      end
    end else if (req.key == kmsd_pkg::KEY_NONE) begin
      prev_key_next     = kmsd_pkg::KEY_NONE;
      stable_count_next = '0;
    end else if (req.key == prev_key &&
                 {1'b0, debounce_ticks} < stable_count) begin
      // Accepted key still held: report it as held and leave state alone.
      result = kmsd_pkg::KEY_HELD;
    end else begin
      if (req.key == prev_key) begin
        stable_count_next = stable_count + 1'b1;
      end else begin
        stable_count_next = '0;
      end
      prev_key_next = req.key;
      if (stable_count_next == {1'b0, debounce_ticks}) begin
        key_ready_next    = 1'b1;
        accepted_key_next = req.key;
      end
    end
  end

  // Configuration register and debounce state.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= kmsd_pkg::DEBOUNCE_RESET;
      prev_key       <= '0;
      stable_count   <= '0;
      key_ready      <= 1'b0;
      accepted_key   <= '0;
    end else begin
      if (cfg_valid) begin
        debounce_ticks <= cfg_data;
      end
      if (push) begin
        prev_key     <= prev_key_next;
        stable_count <= stable_count_next;
        key_ready    <= key_ready_next;
        accepted_key <= accepted_key_next;
      end
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_code   <= skid_code;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_code  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_code  <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without a result in front");

  // A ready character appears only after an accepted scan tick.
  a_ready_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(key_ready) |-> $past(push && req.read == kmsd_pkg::REQ_SCAN))
    else $error("key_ready set without a scan tick");

  // A read always leaves no character pending.
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    push && req.read == kmsd_pkg::REQ_READ |=> !key_ready)
    else $error("read left key_ready set");

  // After an accepted request a result is always valid in the next cycle.
  a_push_gives_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("accepted request produced no result");

endmodule

// ===== src/keypad_matrix_scan_debounce.sv =====
// Top level of the 4x4 keypad scanner with debounce.
//
//   channel   role    fields
//   req       sink    req_type, cols_row4, cols_row3, cols_row2, cols_row1
//   res       source  result_code
//   cfg       sink    data (debounce_ticks)
//
// Four row lanes decode each request in parallel, the merge stage picks R4
// first, and the debounce state updates at the accepting edge. The result is
// registered. While a result waits, one more request goes into a skid entry;
// the input then stalls until that entry moves up, and the cycle in which it
// moves up takes no new request. Reset is synchronous and clears all state
// but the result codes; debounce_ticks returns to 3.
`timescale 1ns / 1ps

module keypad_matrix_scan_debounce (
  input logic         clk,
  input logic         rst,
  kmsd_req_if.sink    req,
  kmsd_res_if.source  res,
  kmsd_cfg_if.sink    cfg
);

  logic [3:0]          row_cols [kmsd_pkg::Rows];
  kmsd_pkg::lane_hit_t lanes    [kmsd_pkg::Rows];
  kmsd_pkg::scan_req_t scan_req;

  // Lane order follows the search order: R4 first.
  assign row_cols[0] = req.cols_row4;
  assign row_cols[1] = req.cols_row3;
  assign row_cols[2] = req.cols_row2;
  assign row_cols[3] = req.cols_row1;

  for (genvar r = 0; r < kmsd_pkg::Rows; r++) begin : g_lane
    kmsd_row_lane u_lane (
      .cols  (row_cols[r]),
      .found (lanes[r])
    );
  end

  kmsd_merge u_merge (
    .lanes (lanes),
    .key   (scan_req.key)
  );

  assign scan_req.read = req.req_type;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  kmsd_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .req       (scan_req),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_code  (res.result_code)
  );

endmodule
